// ===== src/button_gesture_and_blink_code_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the button gesture and blink code block
// Two property shapes: same-cycle implication and next-cycle implication.
// ---------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_AND_BLINK_CODE_TOP_MACROS_SVH
`define BUTTON_GESTURE_AND_BLINK_CODE_TOP_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define BGBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define BGBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bgbc_pkg.sv =====
// ---------------------------------------------------------------------------
// bgbc_pkg
// Shared types and constants of the button gesture and blink code block.
// ---------------------------------------------------------------------------
package bgbc_pkg;

  localparam int NOW_W       = 32;
  localparam int MS_W        = 16;
  localparam int PAUSE_W     = 8;
  localparam int BLK_W       = 9;
  localparam int PASS_W      = 3;
  localparam int CHECK_COUNT = 4;

  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_WINDOW    = 3'd0;
  localparam logic [2:0] REG_LONG_HOLD = 3'd1;
  localparam logic [2:0] REG_SINGLE_TO = 3'd2;
  localparam logic [2:0] REG_PAUSE     = 3'd3;
  localparam logic [2:0] REG_REPORT_EN = 3'd4;

  localparam logic [MS_W-1:0]    RST_WINDOW    = 16'd5000;
  localparam logic [MS_W-1:0]    RST_LONG_HOLD = 16'd3000;
  localparam logic [MS_W-1:0]    RST_SINGLE_TO = 16'd1500;
  localparam logic [PAUSE_W-1:0] RST_PAUSE     = 8'd4;
  localparam logic               RST_REPORT_EN = 1'b1;

  // input tdata bit positions
  localparam int IN_BUTTON_BIT = 32;
  localparam int IN_PILOT_BIT  = 33;
  localparam int IN_CURRENT_BIT = 34;
  localparam int IN_COOL_BIT   = 35;
  localparam int IN_ENABLE_BIT = 36;
  localparam int IN_ACTIVE_BIT = 37;

  // output tdata bit positions
  localparam int OUT_ACT_BIT  = 0;
  localparam int OUT_CAN_BIT  = 1;
  localparam int OUT_GW_BIT   = 2;
  localparam int OUT_GL_BIT   = 3;
  localparam int OUT_RW_BIT   = 4;
  localparam int OUT_RL_BIT   = 5;
  localparam int OUT_REP_BIT  = 6;
  localparam int OUT_TS_BIT   = 7;
  localparam int OUT_BUSY_BIT = 8;

  typedef struct packed {
    logic [MS_W-1:0]    window_ms;
    logic [MS_W-1:0]    long_hold_ms;
    logic [MS_W-1:0]    single_timeout_ms;
    logic [PAUSE_W-1:0] pause_ticks;
    logic               report_enabled;
  } cfg_t;

  typedef struct packed {
    logic load;    // capture the input beat
    logic expire;  // drop the oldest recorded press
    logic finish;  // commit the tick and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic expire_hit;  // oldest press is out of the window on a press tick
  } dp_sts_t;

  // last field in the lowest bit
  typedef struct packed {
    logic busy_res;
    logic test_started;
    logic report_pulse;
    logic red_level;
    logic red_write;
    logic green_level;
    logic green_write;
    logic cancel_pulse;
    logic activate_pulse;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

// ===== src/bgbc_regs.sv =====
// ---------------------------------------------------------------------------
// bgbc_regs
// Configuration register file behind an APB-style port.
// ---------------------------------------------------------------------------
module bgbc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bgbc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [bgbc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [bgbc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output bgbc_pkg::cfg_t                cfg
);

  bgbc_pkg::cfg_t cfg_r;
  bgbc_pkg::cfg_t cfg_nxt;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        bgbc_pkg::REG_WINDOW:    cfg_nxt.window_ms         = cfg_pwdata[bgbc_pkg::MS_W-1:0];
        bgbc_pkg::REG_LONG_HOLD: cfg_nxt.long_hold_ms      = cfg_pwdata[bgbc_pkg::MS_W-1:0];
        bgbc_pkg::REG_SINGLE_TO: cfg_nxt.single_timeout_ms = cfg_pwdata[bgbc_pkg::MS_W-1:0];
        bgbc_pkg::REG_PAUSE:     cfg_nxt.pause_ticks       = cfg_pwdata[bgbc_pkg::PAUSE_W-1:0];
        bgbc_pkg::REG_REPORT_EN: cfg_nxt.report_enabled    = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ms         <= bgbc_pkg::RST_WINDOW;
      cfg_r.long_hold_ms      <= bgbc_pkg::RST_LONG_HOLD;
      cfg_r.single_timeout_ms <= bgbc_pkg::RST_SINGLE_TO;
      cfg_r.pause_ticks       <= bgbc_pkg::RST_PAUSE;
      cfg_r.report_enabled    <= bgbc_pkg::RST_REPORT_EN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      bgbc_pkg::REG_WINDOW:    cfg_prdata = {16'd0, cfg_r.window_ms};
      bgbc_pkg::REG_LONG_HOLD: cfg_prdata = {16'd0, cfg_r.long_hold_ms};
      bgbc_pkg::REG_SINGLE_TO: cfg_prdata = {16'd0, cfg_r.single_timeout_ms};
      bgbc_pkg::REG_PAUSE:     cfg_prdata = {24'd0, cfg_r.pause_ticks};
      bgbc_pkg::REG_REPORT_EN: cfg_prdata = {31'd0, cfg_r.report_enabled};
      default:                 cfg_prdata = '0;
    endcase
  end

endmodule

// ===== src/bgbc_ctrl.sv =====
// ---------------------------------------------------------------------------
// bgbc_ctrl
// Sequencer: capture a tick, expire old presses one per cycle, commit.
// ---------------------------------------------------------------------------
module bgbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  bgbc_pkg::dp_sts_t sts,
  output bgbc_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXPIRE = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXPIRE;
        end
      end
      S_EXPIRE: begin
        if (sts.expire_hit) begin
          cmd.expire = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/bgbc_dp.sv =====
// ---------------------------------------------------------------------------
// bgbc_dp
// Datapath: press history, gesture timers, blink sequencer, result register.
// ---------------------------------------------------------------------------
module bgbc_dp #(
  parameter int TRIGGER_PRESSES = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bgbc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  bgbc_pkg::cfg_t                    cfg,
  input  bgbc_pkg::dp_cmd_t                 cmd,
  output bgbc_pkg::dp_sts_t                 sts,
  output bgbc_pkg::result_t                 res
);

  localparam int CNT_W = $clog2(TRIGGER_PRESSES + 1);
  localparam int IDX_W = $clog2(TRIGGER_PRESSES);
  localparam int NW    = bgbc_pkg::NOW_W;
  localparam int BW    = bgbc_pkg::BLK_W;

  // captured tick
  logic [NW-1:0] now_r;
  logic          down_r;
  logic [3:0]    checks_r;
  logic          active_r;

  logic [NW-1:0]    hist_r [TRIGGER_PRESSES];
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             prev_down_r, prev_down_nxt;
  logic             single_wait_r, single_wait_nxt;
  logic [NW-1:0]    single_stamp_r, single_stamp_nxt;
  logic [NW-1:0]    hold_stamp_r, hold_stamp_nxt;
  logic             hold_tracking_r, hold_tracking_nxt;
  logic             hold_fired_r, hold_fired_nxt;
  logic             blink_mode_r, blink_mode_nxt;
  logic [BW-1:0]    blink_count_r, blink_count_nxt;
  logic [BW-1:0]    green_end_r, green_end_nxt;
  logic [BW-1:0]    red_start_r, red_start_nxt;
  logic [BW-1:0]    blink_total_r, blink_total_nxt;
  logic             report_wait_r, report_wait_nxt;
  bgbc_pkg::result_t res_r, res_nxt;

  logic                        rise;
  logic                        room;
  logic [CNT_W-1:0]            pushed;
  logic [NW-1:0]               age;
  logic [NW-1:0]               hold_elapsed;
  logic [NW-1:0]               single_elapsed;
  logic [bgbc_pkg::PASS_W-1:0] passed;
  logic [bgbc_pkg::PASS_W-1:0] failed;
  logic [BW-1:0]               green2;
  logic [BW-1:0]               fail2;

  assign rise   = down_r && !prev_down_r;
  assign room   = total_r < CNT_W'(TRIGGER_PRESSES);
  assign age    = now_r - hist_r[0];
  assign sts.expire_hit = !blink_mode_r && rise && (total_r != '0) &&
                          (age > {16'd0, cfg.window_ms});
  assign res    = res_r;

  assign passed = bgbc_pkg::PASS_W'(checks_r[0]) + bgbc_pkg::PASS_W'(checks_r[1]) +
                  bgbc_pkg::PASS_W'(checks_r[2]) + bgbc_pkg::PASS_W'(checks_r[3]);
  assign failed = bgbc_pkg::PASS_W'(bgbc_pkg::CHECK_COUNT) - passed;
  assign green2 = {5'd0, passed, 1'b0};
  assign fail2  = {5'd0, failed, 1'b0};
  assign pushed = room ? total_r + CNT_W'(1) : total_r;

  always_comb begin
    total_nxt         = total_r;
    prev_down_nxt     = prev_down_r;
    single_wait_nxt   = single_wait_r;
    single_stamp_nxt  = single_stamp_r;
    hold_stamp_nxt    = hold_stamp_r;
    hold_tracking_nxt = hold_tracking_r;
    hold_fired_nxt    = hold_fired_r;
    blink_mode_nxt    = blink_mode_r;
    blink_count_nxt   = blink_count_r;
    green_end_nxt     = green_end_r;
    red_start_nxt     = red_start_r;
    blink_total_nxt   = blink_total_r;
    report_wait_nxt   = report_wait_r;
    res_nxt           = '0;
    hold_elapsed      = '0;
    single_elapsed    = '0;

    if (blink_mode_r) begin
      if (blink_count_r < green_end_r) begin
        res_nxt.green_write = 1'b1;
        res_nxt.green_level = !blink_count_r[0];
        blink_count_nxt     = blink_count_r + BW'(1);
      end else if (blink_count_r < red_start_r) begin
        // dark pause: both lamps driven off
        res_nxt.green_write = 1'b1;
        res_nxt.red_write   = 1'b1;
        blink_count_nxt     = blink_count_r + BW'(1);
      end else if (blink_count_r < blink_total_r) begin
        res_nxt.red_write = 1'b1;
        res_nxt.red_level = !(blink_count_r[0] ^ red_start_r[0]);
        blink_count_nxt   = blink_count_r + BW'(1);
      end else begin
        res_nxt.green_write = 1'b1;
        res_nxt.red_write   = 1'b1;
        if (report_wait_r && cfg.report_enabled) begin
          res_nxt.report_pulse = 1'b1;
          report_wait_nxt      = 1'b0;
        end
        blink_mode_nxt = 1'b0;
      end
    end else begin
      if (rise) begin
        if (pushed >= CNT_W'(TRIGGER_PRESSES)) begin
          total_nxt       = '0;
          single_wait_nxt = 1'b0;
          green_end_nxt   = green2;
          if (passed == '0) begin
            red_start_nxt   = '0;
            blink_total_nxt = fail2;
          end else if (failed == '0) begin
            red_start_nxt   = green2;
            blink_total_nxt = green2;
          end else begin
            red_start_nxt   = green2 + {1'b0, cfg.pause_ticks};
            blink_total_nxt = green2 + {1'b0, cfg.pause_ticks} + fail2;
          end
          report_wait_nxt      = failed != '0;
          blink_count_nxt      = '0;
          blink_mode_nxt       = 1'b1;
          res_nxt.test_started = 1'b1;
        end else if (pushed == CNT_W'(1)) begin
          total_nxt        = pushed;
          single_wait_nxt  = 1'b1;
          single_stamp_nxt = now_r;
        end else begin
          total_nxt       = pushed;
          single_wait_nxt = 1'b0;
        end
        hold_stamp_nxt    = now_r;
        hold_tracking_nxt = 1'b1;
        hold_fired_nxt    = 1'b0;
      end
      if (!down_r && prev_down_r) begin
        hold_tracking_nxt = 1'b0;
      end
      hold_elapsed = now_r - hold_stamp_nxt;
      if (down_r && hold_tracking_nxt && !hold_fired_nxt &&
          hold_elapsed >= {16'd0, cfg.long_hold_ms}) begin
        hold_fired_nxt       = 1'b1;
        single_wait_nxt      = 1'b0;
        total_nxt            = '0;
        res_nxt.cancel_pulse = active_r;
      end
      single_elapsed = now_r - single_stamp_nxt;
      if (single_wait_nxt && !down_r &&
          single_elapsed >= {16'd0, cfg.single_timeout_ms}) begin
        single_wait_nxt        = 1'b0;
        total_nxt              = '0;
        res_nxt.activate_pulse = 1'b1;
      end
      prev_down_nxt = down_r;
    end
    res_nxt.busy_res = blink_mode_nxt;
  end

  // input capture and result register: payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r    <= in_tdata[NW-1:0];
      down_r   <= in_tdata[bgbc_pkg::IN_BUTTON_BIT];
      checks_r <= in_tdata[bgbc_pkg::IN_ENABLE_BIT:bgbc_pkg::IN_PILOT_BIT];
      active_r <= in_tdata[bgbc_pkg::IN_ACTIVE_BIT];
    end
    if (cmd.finish) begin
      res_r <= res_nxt;
    end
  end

  // history shifts toward slot 0 on expiry; a new press lands at the fill level
  always_ff @(posedge clk) begin
    if (cmd.expire) begin
      for (int i = 1; i < TRIGGER_PRESSES; i++) begin
        hist_r[i-1] <= hist_r[i];
      end
    end else if (cmd.finish && !blink_mode_r && rise && room) begin
      hist_r[total_r[IDX_W-1:0]] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r         <= '0;
      prev_down_r     <= 1'b0;
      single_wait_r   <= 1'b0;
      single_stamp_r  <= '0;
      hold_stamp_r    <= '0;
      hold_tracking_r <= 1'b0;
      hold_fired_r    <= 1'b0;
      blink_mode_r    <= 1'b0;
      blink_count_r   <= '0;
      green_end_r     <= '0;
      red_start_r     <= '0;
      blink_total_r   <= '0;
      report_wait_r   <= 1'b0;
    end else if (cmd.expire) begin
      total_r <= total_r - CNT_W'(1);
    end else if (cmd.finish) begin
      total_r         <= total_nxt;
      prev_down_r     <= prev_down_nxt;
      single_wait_r   <= single_wait_nxt;
      single_stamp_r  <= single_stamp_nxt;
      hold_stamp_r    <= hold_stamp_nxt;
      hold_tracking_r <= hold_tracking_nxt;
      hold_fired_r    <= hold_fired_nxt;
      blink_mode_r    <= blink_mode_nxt;
      blink_count_r   <= blink_count_nxt;
      green_end_r     <= green_end_nxt;
      red_start_r     <= red_start_nxt;
      blink_total_r   <= blink_total_nxt;
      report_wait_r   <= report_wait_nxt;
    end
  end

endmodule

// ===== src/button_gesture_and_blink_code_top.sv =====
// ---------------------------------------------------------------------------
// button_gesture_and_blink_code_top
// Button gesture recognizer and self-test blink-code player, one result beat
// per tick beat. A tick is captured on acceptance; the controller then steps
// through its expire and done states, and the result register is loaded in
// the done state before the next tick is taken. A press tick stays in the
// expire state while stale presses are dropped from the history, at most
// TRIGGER_PRESSES - 1 of them; the expiry sequencer in the controller drops
// one press per cycle. A finished result waits in the output register while
// the next tick is taken. That tick then holds in its commit step until the
// waiting beat leaves. Gestures: lone press (activate after the release
// timeout), long hold (cancel while charging), TRIGGER_PRESSES presses
// inside the window (self-test with green/red blink code and an optional
// failure report).
// ---------------------------------------------------------------------------
`include "button_gesture_and_blink_code_top_macros.svh"

module button_gesture_and_blink_code_top #(
  parameter int TRIGGER_PRESSES = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [31:0] now_ms, [32] button_down, [33] pilot_ok, [34] current_ok,
  //           [35] cool_ok, [36] enable_ok, [37] charge_active, [39:38] zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bgbc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: [0] activate_pulse, [1] cancel_pulse, [2] green_write,
  //            [3] green_level, [4] red_write, [5] red_level, [6] report_pulse,
  //            [7] test_started, [8] busy_res, [15:9] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bgbc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bgbc_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [bgbc_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [bgbc_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  bgbc_pkg::cfg_t    cfg;
  bgbc_pkg::dp_cmd_t cmd;
  bgbc_pkg::dp_sts_t sts;
  bgbc_pkg::result_t res;

  logic in_beat;
  logic test_beat;
  logic lamp_ok;
  logic gesture_ok;

  bgbc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bgbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bgbc_dp #(
    .TRIGGER_PRESSES (TRIGGER_PRESSES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tdata (in_tdata),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .res      (res)
  );

  assign out_tdata = {(bgbc_pkg::OUT_TDATA_W - bgbc_pkg::RES_W)'(0), res};

  assign in_beat    = in_tvalid && in_tready;
  assign test_beat  = out_tvalid && res.test_started;
  assign lamp_ok    = (res.green_write || !res.green_level) &&
                      (res.red_write || !res.red_level);
  assign gesture_ok = !(res.activate_pulse && (res.cancel_pulse || res.test_started));

  // a captured tick is always worked on before the next one is taken
  `BGBC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_beat, !in_tready, "tick taken while busy")
  // a started self-test means blink mode afterwards
  `BGBC_ASSERT_IMP(a_test_busy, clk, rst_n, test_beat, res.busy_res, "test without busy")
  // a lamp level is only ever on when that lamp is driven
  `BGBC_ASSERT_IMP(a_level_write, clk, rst_n, out_tvalid, lamp_ok, "lamp level without write")
  // an activate never comes with a cancel or a self-test start
  `BGBC_ASSERT_IMP(a_gesture_excl, clk, rst_n, out_tvalid, gesture_ok, "gesture clash")

endmodule

// ===== dv/tb_button_gesture_and_blink_code_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_button_gesture_and_blink_code_top
// Self-checking bench for the button gesture / blink code block. A short
// table of directed ticks is followed by random gesture sequences (press
// bursts, lone presses, long holds, quiet gaps, noise) under several register
// settings. Every result beat is checked field by field against a typed-in
// result or the in-bench model of the gesture recognizer and the blink player.
// ---------------------------------------------------------------------------
module tb_button_gesture_and_blink_code_top;

  localparam int          NPRESS          = 5;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          SETTLE_CYCLES   = 16;
  localparam logic [31:0] T0              = 32'hFFFF_FC00;  // directed ticks wrap past zero

  // now in the lowest bits, same layout as in_tdata
  typedef struct packed {
    logic        active;
    logic [3:0]  checks;  // [0] pilot, [1] current, [2] cool, [3] enable
    logic        down;
    logic [31:0] now;
  } tick_t;

  typedef struct packed {
    logic [31:0]       now;
    logic              down;
    logic [3:0]        checks;
    logic              active;
    logic              fixed_ok;  // use the typed-in result instead of the model
    bgbc_pkg::result_t fixed;
  } dir_row_t;

  localparam int TICK_W = $bits(tick_t);
  localparam int CFG_W  = $bits(bgbc_pkg::cfg_t);

  localparam bgbc_pkg::result_t R_NONE        = '0;
  localparam bgbc_pkg::result_t R_ACT         = '{activate_pulse: 1'b1, default: 1'b0};
  localparam bgbc_pkg::result_t R_CAN         = '{cancel_pulse: 1'b1, default: 1'b0};
  localparam bgbc_pkg::result_t R_TRIGGER     = '{test_started: 1'b1, busy_res: 1'b1,
                                                  default: 1'b0};
  localparam bgbc_pkg::result_t R_DONE_REPORT = '{green_write: 1'b1, red_write: 1'b1,
                                                  report_pulse: 1'b1, default: 1'b0};

  localparam int DIR_N = 26;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{T0 + 32'd0,    1'b0, 4'hF, 1'b0, 1'b1, R_NONE},
    '{T0 + 32'd100,  1'b1, 4'h0, 1'b1, 1'b1, R_NONE},
    '{T0 + 32'd200,  1'b0, 4'h5, 1'b1, 1'b1, R_NONE},
    '{T0 + 32'd1700, 1'b0, 4'hA, 1'b0, 1'b1, R_ACT},
    '{T0 + 32'd2000, 1'b1, 4'h3, 1'b1, 1'b1, R_NONE},
    '{T0 + 32'd5000, 1'b1, 4'hC, 1'b1, 1'b1, R_CAN},
    '{T0 + 32'd5200, 1'b0, 4'h0, 1'b1, 1'b1, R_NONE},
    // five presses inside the window, all checks failing on the trigger
    '{T0 + 32'd6000, 1'b1, 4'h1, 1'b0, 1'b0, R_NONE},
    '{T0 + 32'd6100, 1'b0, 4'h2, 1'b0, 1'b0, R_NONE},
    '{T0 + 32'd6200, 1'b1, 4'h4, 1'b1, 1'b0, R_NONE},
    '{T0 + 32'd6300, 1'b0, 4'h8, 1'b0, 1'b0, R_NONE},
    '{T0 + 32'd6400, 1'b1, 4'hF, 1'b1, 1'b0, R_NONE},
    '{T0 + 32'd6500, 1'b0, 4'h7, 1'b0, 1'b0, R_NONE},
    '{T0 + 32'd6600, 1'b1, 4'hE, 1'b1, 1'b0, R_NONE},
    '{T0 + 32'd6700, 1'b0, 4'h9, 1'b0, 1'b0, R_NONE},
    '{T0 + 32'd6800, 1'b1, 4'h0, 1'b1, 1'b1, R_TRIGGER},
    // red blinks, button toggling is ignored
    '{T0 + 32'd7000, 1'b0, 4'hF, 1'b0, 1'b0, R_NONE},
    '{T0 + 32'd7100, 1'b1, 4'h0, 1'b1, 1'b0, R_NONE},
    '{T0 + 32'd7200, 1'b0, 4'h6, 1'b0, 1'b0, R_NONE},
    '{T0 + 32'd7300, 1'b1, 4'h9, 1'b1, 1'b0, R_NONE},
    '{T0 + 32'd7400, 1'b1, 4'h3, 1'b0, 1'b0, R_NONE},
    '{T0 + 32'd7500, 1'b0, 4'hC, 1'b1, 1'b0, R_NONE},
    '{T0 + 32'd7600, 1'b1, 4'h5, 1'b0, 1'b0, R_NONE},
    '{T0 + 32'd7700, 1'b0, 4'hA, 1'b1, 1'b0, R_NONE},
    '{T0 + 32'd7800, 1'b1, 4'h1, 1'b0, 1'b1, R_DONE_REPORT},
    // released while blinking: falling edge seen once idle again
    '{T0 + 32'd7900, 1'b0, 4'h2, 1'b1, 1'b0, R_NONE}
  };

  string res_field [bgbc_pkg::RES_W] = '{"activate_pulse", "cancel_pulse", "green_write",
                                         "green_level", "red_write", "red_level",
                                         "report_pulse", "test_started", "busy_res"};

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  // in_tdata: now_ms, button_down, pilot_ok, current_ok, cool_ok, enable_ok,
  //           charge_active, zero pad
  logic [bgbc_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  // out_tdata: activate_pulse, cancel_pulse, green_write, green_level,
  //            red_write, red_level, report_pulse, test_started, busy_res, zero pad
  logic [bgbc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_psel;
  logic                             cfg_penable;
  logic                             cfg_pwrite;
  logic [bgbc_pkg::CFG_AW-1:0]      cfg_paddr;
  logic [bgbc_pkg::CFG_DW-1:0]      cfg_pwdata;
  logic [bgbc_pkg::CFG_DW-1:0]      cfg_prdata;
  logic                             cfg_pready;

  button_gesture_and_blink_code_top #(
    .TRIGGER_PRESSES(NPRESS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------- gesture / blink model state ----------------
  bgbc_pkg::cfg_t cur_cfg = '{window_ms: bgbc_pkg::RST_WINDOW,
                              long_hold_ms: bgbc_pkg::RST_LONG_HOLD,
                              single_timeout_ms: bgbc_pkg::RST_SINGLE_TO,
                              pause_ticks: bgbc_pkg::RST_PAUSE,
                              report_enabled: bgbc_pkg::RST_REPORT_EN};
  logic [31:0] press_ms [NPRESS];
  int          n_press      = 0;
  bit          last_down    = 0;
  bit          single_armed = 0;
  logic [31:0] single_t0    = '0;
  logic [31:0] hold_t0      = '0;
  bit          holding      = 0;
  bit          hold_done    = 0;
  bit          in_blink     = 0;
  int          blink_pos    = 0;
  int          green_stop   = 0;
  int          red_from     = 0;
  int          blink_stop   = 0;
  bit          report_due   = 0;

  bgbc_pkg::result_t pending_results [$];
  int          n_errors     = 0;
  int          n_checked    = 0;
  int unsigned ticks_sent   = 0;
  int          n_tests      = 0;
  int          n_activates  = 0;
  int          n_cancels    = 0;
  int          n_reports    = 0;
  int          n_settings   = 0;
  int          stall_cycles = 0;
  bit          gaps_on      = 1;
  bit          hold_off_req = 0;
  logic [31:0] wall_ms      = '0;

  function automatic bgbc_pkg::result_t tick_step(tick_t t);
    bgbc_pkg::result_t r;
    int      passed;
    int      failed;
    int      i;
    r = '0;
    passed = $countones(t.checks);
    failed = bgbc_pkg::CHECK_COUNT - passed;
    if (in_blink) begin
      if (blink_pos < green_stop) begin
        r.green_write = 1'b1;
        r.green_level = (blink_pos % 2 == 0);
        blink_pos++;
      end else if (blink_pos < red_from) begin
        r.green_write = 1'b1;
        r.red_write   = 1'b1;
        blink_pos++;
      end else if (blink_pos < blink_stop) begin
        r.red_write = 1'b1;
        r.red_level = ((blink_pos - red_from) % 2 == 0);
        blink_pos++;
      end else begin
        r.green_write = 1'b1;
        r.red_write   = 1'b1;
        if (report_due && cur_cfg.report_enabled) begin
          r.report_pulse = 1'b1;
          report_due = 0;
        end
        in_blink = 0;
      end
    end else begin
      if (t.down && !last_down) begin
        // expire stale presses, oldest first
        while (n_press > 0 && (t.now - press_ms[0]) > {16'd0, cur_cfg.window_ms}) begin
          for (i = 1; i < n_press && i < NPRESS; i++) press_ms[i-1] = press_ms[i];
          n_press--;
        end
        if (n_press < NPRESS) begin
          press_ms[n_press] = t.now;
          n_press++;
        end
        if (n_press >= NPRESS) begin
          n_press = 0;
          single_armed = 0;
          green_stop = passed * 2;
          if (passed == 0) begin
            red_from   = 0;
            blink_stop = failed * 2;
          end else if (failed == 0) begin
            red_from   = green_stop;
            blink_stop = green_stop;
          end else begin
            red_from   = green_stop + cur_cfg.pause_ticks;
            blink_stop = red_from + failed * 2;
          end
          report_due = (failed > 0);
          blink_pos  = 0;
          in_blink   = 1;
          r.test_started = 1'b1;
        end else if (n_press == 1) begin
          single_armed = 1;
          single_t0 = t.now;
        end else begin
          single_armed = 0;
        end
        hold_t0   = t.now;
        holding   = 1;
        hold_done = 0;
      end
      if (!t.down && last_down) holding = 0;
      if (t.down && holding && !hold_done &&
          (t.now - hold_t0) >= {16'd0, cur_cfg.long_hold_ms}) begin
        hold_done = 1;
        single_armed = 0;
        n_press = 0;
        if (t.active) r.cancel_pulse = 1'b1;
      end
      if (single_armed && !t.down &&
          (t.now - single_t0) >= {16'd0, cur_cfg.single_timeout_ms}) begin
        single_armed = 0;
        n_press = 0;
        r.activate_pulse = 1'b1;
      end
      last_down = t.down;
    end
    r.busy_res = in_blink;
    return r;
  endfunction

  function automatic logic [31:0] reg_value(bgbc_pkg::cfg_t c, logic [2:0] idx);
    case (idx)
      bgbc_pkg::REG_WINDOW:    return 32'(c.window_ms);
      bgbc_pkg::REG_LONG_HOLD: return 32'(c.long_hold_ms);
      bgbc_pkg::REG_SINGLE_TO: return 32'(c.single_timeout_ms);
      bgbc_pkg::REG_PAUSE:     return 32'(c.pause_ticks);
      bgbc_pkg::REG_REPORT_EN: return 32'(c.report_enabled);
      default:                 return '0;
    endcase
  endfunction

  // ---------------- clock, reset ----------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- tick driver ----------------
  task automatic send_tick(tick_t t, bit fixed_ok, bgbc_pkg::result_t fixed);
    bgbc_pkg::result_t r;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bgbc_pkg::IN_TDATA_W'(t);
    do @(posedge clk); while (!in_tready);
    r = tick_step(t);
    if (fixed_ok) r = fixed;
    pending_results.push_back(r);
    ticks_sent++;
    n_tests     += r.test_started;
    n_activates += r.activate_pulse;
    n_cancels   += r.cancel_pulse;
    n_reports   += r.report_pulse;
  endtask

  task automatic gen_tick(bit down, int unsigned span);
    tick_t t;
    wall_ms  = wall_ms + $urandom_range(0, span);
    t.now    = wall_ms;
    t.down   = down;
    t.checks = 4'($urandom_range(0, 15));
    t.active = 1'($urandom_range(0, 1));
    send_tick(t, 1'b0, R_NONE);
  endtask

  task automatic play_gestures(int unsigned n);
    int unsigned stop_at;
    int unsigned span;
    int unsigned reps;
    int          k;
    tick_t       t;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // press burst, mostly enough presses to start a self-test
          reps = ($urandom_range(0, 2) != 0) ? NPRESS : $urandom_range(2, NPRESS + 2);
          span = (cur_cfg.window_ms * $urandom_range(1, 3)) / (4 * reps) + 1;
          for (k = 0; k < reps; k++) begin
            gen_tick(1'b1, span);
            if ($urandom_range(0, 3) == 0) gen_tick(1'b1, span);
            gen_tick(1'b0, span);
          end
        end
        4, 5: begin
          span = cur_cfg.single_timeout_ms / 2 + 1;
          gen_tick(1'b1, span);
          reps = $urandom_range(1, 4);
          for (k = 0; k < reps; k++) gen_tick(1'b0, span);
        end
        6, 7: begin
          span = cur_cfg.long_hold_ms / 3 + 1;
          gen_tick(1'b1, span);
          reps = $urandom_range(1, 5);
          for (k = 0; k < reps; k++) gen_tick(1'b1, span);
          gen_tick(1'b0, span);
        end
        8: begin
          reps = $urandom_range(1, 4);
          for (k = 0; k < reps; k++) gen_tick(1'b0, 70000);
        end
        default: begin
          // noise: random levels and clock jumps
          reps = $urandom_range(1, 6);
          for (k = 0; k < reps; k++) begin
            wall_ms = $urandom();
            t = tick_t'(TICK_W'({$urandom(), $urandom()}));
            t.now = wall_ms;
            send_tick(t, 1'b0, R_NONE);
          end
        end
      endcase
      while (in_blink) gen_tick(1'($urandom_range(0, 1)), 1000);
    end
  endtask

  // drop valid, let every result come back and the pipe go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------- register port ----------------
  task automatic cfg_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    for (int r = bgbc_pkg::REG_WINDOW; r <= bgbc_pkg::REG_REPORT_EN; r++) begin
      cfg_access(1'b0, 3'(r), '0, rd);
      if (rd !== reg_value(cur_cfg, 3'(r))) begin
        n_errors++;
        $display("%0t: register %0d readback expected %h, got %h",
                 $time, r, reg_value(cur_cfg, 3'(r)), rd);
      end
    end
  endtask

  task automatic apply_cfg(bgbc_pkg::cfg_t c);
    logic [31:0] rd;
    logic [31:0] wdata;
    for (int r = bgbc_pkg::REG_WINDOW; r <= bgbc_pkg::REG_REPORT_EN; r++) begin
      // junk above the register width must be dropped
      wdata = reg_value(c, 3'(r)) | ($urandom() & ~reg_value('1, 3'(r)));
      cfg_access(1'b1, 3'(r), wdata, rd);
    end
    cur_cfg = c;
    n_settings++;
    check_regs();
  endtask

  // ---------------- result side ----------------
  initial begin : result_ready
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    bgbc_pkg::result_t got;
    bgbc_pkg::result_t want;
    int      i;
    if (rst_n && out_tvalid && out_tready) begin
      got = bgbc_pkg::result_t'(out_tdata[bgbc_pkg::RES_W-1:0]);
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: result beat with none pending, expected nothing, got %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        for (i = 0; i < bgbc_pkg::RES_W; i++) begin
          if (got[i] !== want[i]) begin
            n_errors++;
            $display("%0t: %s expected %0b, got %0b", $time, res_field[i], want[i], got[i]);
          end
        end
        if (out_tdata[bgbc_pkg::OUT_TDATA_W-1:bgbc_pkg::RES_W] !== '0) begin
          n_errors++;
          $display("%0t: pad bits expected 0, got %h", $time,
                   out_tdata[bgbc_pkg::OUT_TDATA_W-1:bgbc_pkg::RES_W]);
        end
      end
    end
  end

  // no beat on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------- sequence ----------------
  initial begin : main_seq
    bgbc_pkg::cfg_t c;
    int   row;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_regs();

    for (row = 0; row < DIR_N; row++)
      send_tick('{active: DIR_ROWS[row].active, checks: DIR_ROWS[row].checks,
                  down: DIR_ROWS[row].down, now: DIR_ROWS[row].now},
                DIR_ROWS[row].fixed_ok, DIR_ROWS[row].fixed);
    wall_ms = DIR_ROWS[DIR_N-1].now;
    settle();

    // reset settings; receiver holds off early so the block backs up
    hold_off_req = 1;
    play_gestures(150);
    settle();

    apply_cfg('{window_ms: 16'hFFFF, long_hold_ms: 16'hFFFF, single_timeout_ms: 16'hFFFF,
                pause_ticks: 8'hFF, report_enabled: 1'b0});
    play_gestures(150);
    settle();

    apply_cfg('{window_ms: '0, long_hold_ms: '0, single_timeout_ms: '0,
                pause_ticks: '0, report_enabled: 1'b1});
    play_gestures(150);
    settle();

    repeat (2) begin
      c.window_ms         = 16'($urandom_range(1000, 8000));
      c.long_hold_ms      = 16'($urandom_range(300, 6000));
      c.single_timeout_ms = 16'($urandom_range(0, 3000));
      c.pause_ticks       = 8'($urandom_range(0, 12));
      c.report_enabled    = 1'($urandom_range(0, 1));
      apply_cfg(c);
      play_gestures(200);
      settle();
    end

    c = bgbc_pkg::cfg_t'(CFG_W'({$urandom(), $urandom()}));
    c.window_ms = 16'($urandom());
    apply_cfg(c);
    play_gestures(150);
    settle();

    // closing stretch runs at full rate on both sides
    gaps_on = 0;
    c = '{window_ms: bgbc_pkg::RST_WINDOW, long_hold_ms: bgbc_pkg::RST_LONG_HOLD,
          single_timeout_ms: bgbc_pkg::RST_SINGLE_TO, pause_ticks: 8'($urandom_range(0, 3)),
          report_enabled: 1'b1};
    apply_cfg(c);
    play_gestures(150);
    settle();

    $display("Ran %0d ticks, %0d results checked, over %0d register settings.",
             ticks_sent, n_checked, n_settings + 1);
    $display("Self-tests %0d, activates %0d, cancels %0d, failure reports %0d.",
             n_tests, n_activates, n_cancels, n_reports);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
